FILE: rtl/csws_pkg.sv
package csws_pkg;

  localparam int unsigned MaxWaitersDef   = 16;
  localparam int unsigned ThreadIdBitsDef = 6;
  localparam int unsigned MaxResults      = 16;
  localparam int unsigned TokenW          = 16;
  localparam int unsigned IdFieldW        = 6;
  localparam int unsigned AmountW         = 8;
  localparam int unsigned ActionW         = 2;
  localparam int unsigned KindW           = 3;

  typedef enum logic [ActionW-1:0] {
    ActGet     = 2'd0,
    ActPut     = 2'd1,
    ActTimeout = 2'd2
  } action_e;

  typedef enum logic [KindW-1:0] {
    EvGranted = 3'd0,
    EvQueued  = 3'd1,
    EvResumed = 3'd2,
    EvRemoved = 3'd3,
    EvFull    = 3'd4
  } ev_kind_e;

  typedef struct packed {
    logic [ActionW-1:0]  action;
    logic [IdFieldW-1:0] thread_id;
    logic [AmountW-1:0]  put_amount;
  } in_t;

  typedef struct packed {
    logic [KindW-1:0]    event_kind;
    logic [IdFieldW-1:0] event_thread;
    logic                last_event;
  } out_t;

  // Command bundle from the sequencer to the token counter.
  typedef struct packed {
    logic               load;
    logic [TokenW-1:0]  load_val;
    logic               add;
    logic [AmountW-1:0] add_val;
    logic               dec;
  } tok_cmd_t;

endpackage

FILE: rtl/csws_ram.sv
module csws_ram #(
  parameter int unsigned Width = 6,
  parameter int unsigned Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/csws_tok.sv
module csws_tok (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  csws_pkg::tok_cmd_t        cmd_i,
  output logic                      nz_o
);
  import csws_pkg::*;

  logic [TokenW-1:0] count_q, count_d;
  logic [TokenW:0]   sum;

  // Saturating add; the sequencer never adds and decrements in one cycle.
  always_comb begin
    sum     = {1'b0, count_q} + (TokenW + 1)'(cmd_i.add_val);
    count_d = count_q;
    if (cmd_i.load) begin
      count_d = cmd_i.load_val;
    end else if (cmd_i.add) begin
      count_d = sum[TokenW] ? '1 : sum[TokenW-1:0];
    end else if (cmd_i.dec) begin
      count_d = count_q - TokenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign nz_o = (count_q != '0);

endmodule

FILE: rtl/counting_semaphore_wait_stack.sv
// Order: a get answers with a registered result; a put first adds its tokens and then
// wakes threads one per cycle; a timeout scans the stack one entry per cycle from the top
// and then moves each entry above the hit down by one.
// Busy covers the wake-up loop of a put and the search and shift of a timeout, which share
// the single read port of the waiter memory; a get leaves the block idle for the next request.
// Reset (asynchronous, active low) empties the stack and zeroes the tokens; no clearing pass.
module counting_semaphore_wait_stack #(
  parameter int unsigned MAX_WAITERS    = csws_pkg::MaxWaitersDef,
  parameter int unsigned THREAD_ID_BITS = csws_pkg::ThreadIdBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  csws_pkg::in_t                req_i,
  input  logic                         cfg_we_i,
  input  logic [csws_pkg::TokenW-1:0]  cfg_wdata_i,
  output logic                         res_valid_o,
  output csws_pkg::out_t               res_o
);
  import csws_pkg::*;

  // Stored thread ids keep only the bits that the configured id width allows.
  localparam int unsigned IdW  = (THREAD_ID_BITS < IdFieldW) ? THREAD_ID_BITS : IdFieldW;
  localparam int unsigned AW   = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int unsigned OW   = $clog2(MAX_WAITERS + 1);
  localparam int unsigned CntW = $clog2(MaxResults + 1);

  typedef logic [OW-1:0]  occ_t;
  typedef logic [OW:0]    occw_t;
  typedef logic [AW-1:0]  addr_t;
  typedef logic [IdW-1:0] id_t;

  // Idle handles gets directly. Wake pops waiters after a put, one per cycle, with
  // the memory read of the next waiter overlapping the report of the current one.
  // Search walks down from the top of the stack looking for the timed-out thread,
  // and Shift closes the gap it leaves, one entry per cycle.
  typedef enum logic [1:0] {
    StIdle,
    StWake,
    StSrch,
    StShift
  } state_e;

  state_e          state_q, state_d;
  occ_t            occ_q, occ_d;
  addr_t           idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pend_q, pend_d;
  id_t             tid_q, tid_d;
  logic            res_valid_q, res_valid_d;
  out_t            res_q, res_d;

  logic     ram_we;
  addr_t    ram_waddr, ram_raddr;
  id_t      ram_wdata, ram_rdata;
  tok_cmd_t tok_cmd;
  logic     tok_nz;

  id_t   tid_in;
  occ_t  occ_m1;
  occw_t idx_w, occ_w;
  logic  wake_more;

  assign tid_in    = req_i.thread_id[IdW-1:0];
  assign occ_m1    = occ_q - occ_t'(1);
  assign idx_w     = occw_t'(idx_q);
  assign occ_w     = occw_t'(occ_q);
  // Another waiter can be woken while tokens remain, a thread waits and the per-put
  // limit on results has not been reached.
  assign wake_more = tok_nz && (occ_q != '0) && (cnt_q < CntW'(MaxResults));

  csws_ram #(
    .Width (IdW),
    .Depth (MAX_WAITERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  csws_tok u_tok (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (tok_cmd),
    .nz_o   (tok_nz)
  );

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    tid_d       = tid_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = addr_t'(occ_q);
    ram_wdata   = tid_in;
    ram_raddr   = '0;
    tok_cmd     = '0;
    tok_cmd.load_val = cfg_wdata_i;
    tok_cmd.add_val  = req_i.put_amount;

    case (state_q)
      StIdle: begin
        if (cfg_we_i) begin
          // A configuration write reinitializes the semaphore.
          tok_cmd.load = 1'b1;
          occ_d        = '0;
        end else if (start) begin
          tid_d = tid_in;
          res_d.event_thread = IdFieldW'(tid_in);
          res_d.last_event   = 1'b1;
          case (req_i.action)
            ActGet: begin
              res_valid_d = 1'b1;
              if (tok_nz) begin
                tok_cmd.dec      = 1'b1;
                res_d.event_kind = EvGranted;
              end else if (occ_q == occ_t'(MAX_WAITERS)) begin
                res_d.event_kind = EvFull;
              end else begin
                ram_we           = 1'b1;
                occ_d            = occ_q + occ_t'(1);
                res_d.event_kind = EvQueued;
              end
            end
            ActPut: begin
              tok_cmd.add = 1'b1;
              cnt_d       = '0;
              state_d     = StWake;
            end
            ActTimeout: begin
              // Nothing waits, so nothing can time out.
              if (occ_q != '0) begin
                ram_raddr = addr_t'(occ_m1);
                idx_d     = addr_t'(occ_m1);
                state_d   = StSrch;
              end
            end
            default: begin
            end
          endcase
        end
      end

      StWake: begin
        if (pend_q) begin
          res_valid_d        = 1'b1;
          res_d.event_kind   = EvResumed;
          res_d.event_thread = IdFieldW'(ram_rdata);
          res_d.last_event   = !wake_more;
        end
        if (wake_more) begin
          tok_cmd.dec = 1'b1;
          occ_d       = occ_m1;
          ram_raddr   = addr_t'(occ_m1);
          cnt_d       = cnt_q + CntW'(1);
          pend_d      = 1'b1;
        end else begin
          state_d = StIdle;
        end
      end

      StSrch: begin
        res_d.event_kind   = EvRemoved;
        res_d.event_thread = IdFieldW'(tid_q);
        res_d.last_event   = 1'b1;
        if (ram_rdata == tid_q) begin
          if (idx_w + occw_t'(1) < occ_w) begin
            ram_raddr = addr_t'(idx_w + occw_t'(1));
            state_d   = StShift;
          end else begin
            occ_d       = occ_m1;
            res_valid_d = 1'b1;
            state_d     = StIdle;
          end
        end else if (idx_q == '0) begin
          state_d = StIdle;
        end else begin
          idx_d     = idx_q - addr_t'(1);
          ram_raddr = idx_q - addr_t'(1);
        end
      end

      StShift: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = ram_rdata;
        idx_d     = addr_t'(idx_w + occw_t'(1));
        res_d.event_kind   = EvRemoved;
        res_d.event_thread = IdFieldW'(tid_q);
        res_d.last_event   = 1'b1;
        if (idx_w + occw_t'(2) < occ_w) begin
          ram_raddr = addr_t'(idx_w + occw_t'(2));
        end else begin
          occ_d       = occ_m1;
          res_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      occ_q       <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tid_q <= tid_d;
    res_q <= res_d;
  end

  assign busy        = (state_q != StIdle);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  // The stack never holds more waiters than it has entries.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= occ_t'(MAX_WAITERS))
    else $error("waiter occupancy beyond stack depth");

  // Every accepted get transaction answers with exactly one final result.
  a_get_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !cfg_we_i && (req_i.action == ActGet) |=>
      res_valid_o && res_o.last_event &&
      (res_o.event_kind == EvGranted || res_o.event_kind == EvQueued ||
       res_o.event_kind == EvFull))
    else $error("get transaction without a single final result");

  // Once the final result of a transaction is shown the sequencer is idle again.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_event |-> !busy)
    else $error("final result while still busy");

  // Resumed threads are reported only by the wake-up loop.
  a_resume_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.event_kind == EvResumed) |-> $past(state_q == StWake))
    else $error("resumed result outside the wake-up loop");
`endif

endmodule

FILE: sim/counting_semaphore_wait_stack_tb.sv
`timescale 1ns / 1ps

module counting_semaphore_wait_stack_tb;
  import csws_pkg::*;

  // Action code 3 has no meaning in the block; it must be accepted and ignored.
  localparam logic [ActionW-1:0] ActUnused = 2'd3;
  localparam int unsigned StackDepth = MaxWaitersDef;
  localparam int unsigned TokenCap = (1 << TokenW) - 1;
  // A timeout that finds nothing scans the whole stack at one entry per cycle, so a
  // transaction that yields no result may keep the block busy after its call is taken.
  localparam int unsigned SettleCycles = 2 * StackDepth + 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t req_i = '0;
  logic cfg_we_i = 1'b0;
  logic [TokenW-1:0] cfg_wdata_i = '0;
  logic res_valid_o;
  out_t res_o;

  counting_semaphore_wait_stack dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .req_i(req_i),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .res_valid_o(res_valid_o),
    .res_o(res_o)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the semaphore: token counter, waiter stack and its fill level,
  // plus the value last loaded through the configuration port.
  logic [TokenW-1:0] cfg_tokens = '0;
  logic [TokenW-1:0] sem_tokens = '0;
  logic [IdFieldW-1:0] sem_stack [StackDepth];
  int unsigned sem_depth = 0;

  // Calls still to be issued, and events the semaphore owes us, oldest first.
  in_t call_queue [$];
  out_t due_events [$];

  int unsigned calls_queued = 0;
  int unsigned calls_taken = 0;
  int unsigned gap_pct = 0;
  int unsigned error_count = 0;
  int unsigned events_seen [5];
  int unsigned settings_loaded = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Applies one accepted call to the shadow semaphore and appends the events it
  // must produce; the last of them carries the last flag.
  task automatic sem_apply(input in_t call);
    out_t evs [$];
    out_t ev;
    int unsigned sum;
    int hit;
    ev = '0;
    ev.event_thread = call.thread_id;
    case (call.action)
      ActGet: begin
        if (sem_tokens != 0) begin
          sem_tokens--;
          ev.event_kind = EvGranted;
        end else if (sem_depth >= StackDepth) begin
          ev.event_kind = EvFull;
        end else begin
          sem_stack[sem_depth] = call.thread_id;
          sem_depth++;
          ev.event_kind = EvQueued;
        end
        evs.push_back(ev);
      end
      ActPut: begin
        sum = sem_tokens + call.put_amount;
        sem_tokens = (sum > TokenCap) ? TokenW'(TokenCap) : TokenW'(sum);
        // Wake the newest waiters first while tokens last, at most MaxResults per put.
        while (sem_tokens != 0 && sem_depth != 0 && evs.size() < MaxResults) begin
          sem_tokens--;
          sem_depth--;
          ev.event_kind = EvResumed;
          ev.event_thread = sem_stack[sem_depth];
          evs.push_back(ev);
        end
      end
      ActTimeout: begin
        // The newest entry for the thread goes; the entries above it slide down.
        hit = -1;
        for (int i = int'(sem_depth) - 1; i >= 0 && hit < 0; i--) begin
          if (sem_stack[i] == call.thread_id) hit = i;
        end
        if (hit >= 0) begin
          for (int j = hit; j + 1 < int'(sem_depth); j++) sem_stack[j] = sem_stack[j + 1];
          sem_depth--;
          ev.event_kind = EvRemoved;
          evs.push_back(ev);
        end
      end
      default: begin
      end
    endcase
    if (evs.size() != 0) evs[evs.size() - 1].last_event = 1'b1;
    foreach (evs[k]) due_events.push_back(evs[k]);
  endtask

  // Driver: offers the next pending call, holds it until the block takes it, and
  // leaves random gaps between transactions at the rate of the current phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        sem_apply(req_i);
        calls_taken++;
      end
      if (!start || !busy) begin
        if (call_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
          start <= 1'b1;
          req_i <= call_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest owed event.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && res_valid_o) begin
      if (res_o.event_kind < 5) events_seen[res_o.event_kind]++;
      if (due_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d thread %0d",
                                  res_o.event_kind, res_o.event_thread));
      end else begin
        want = due_events.pop_front();
        if (res_o.event_kind !== want.event_kind)
          report_mismatch($sformatf("event_kind %0d, expected %0d (thread %0d)",
                                    res_o.event_kind, want.event_kind, want.event_thread));
        if (res_o.event_thread !== want.event_thread)
          report_mismatch($sformatf("event_thread %0d, expected %0d",
                                    res_o.event_thread, want.event_thread));
        if (res_o.last_event !== want.last_event)
          report_mismatch($sformatf("last_event %0b, expected %0b (thread %0d)",
                                    res_o.last_event, want.last_event, want.event_thread));
      end
    end
  end

  task automatic queue_call(input logic [ActionW-1:0] act, input int unsigned tid,
                            input int unsigned amount);
    in_t c;
    c.action = act;
    c.thread_id = IdFieldW'(tid);
    c.put_amount = AmountW'(amount);
    call_queue.push_back(c);
    calls_queued++;
  endtask

  // Random call: half gets, the rest puts, timeouts and a little noise. Thread ids
  // come mostly from a small pool so timeouts often find their thread waiting, and
  // puts are mostly tiny so the stack gets a chance to fill up.
  task automatic queue_random_call(input int unsigned put_pct);
    int unsigned pick;
    int unsigned tid;
    int unsigned amount;
    logic [ActionW-1:0] act;
    pick = $urandom_range(99);
    tid = ($urandom_range(99) < 70) ? $urandom_range(7) : $urandom_range(63);
    amount = ($urandom_range(99) < 80) ? $urandom_range(3) : $urandom_range(255);
    if (pick < 50) act = ActGet;
    else if (pick < 50 + put_pct) act = ActPut;
    else if (pick < 97) act = ActTimeout;
    else act = ActUnused;
    queue_call(act, tid, amount);
  endtask

  // Waits until every issued call has been taken and every owed event has come
  // back, then lets the block finish any silent work such as a missed timeout scan.
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (calls_taken != calls_queued || due_events.size() != 0 || busy);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Loading the register also reinitializes the semaphore: tokens reload, stack empties.
  task automatic load_tokens(input logic [TokenW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_tokens = value;
    sem_tokens = cfg_tokens;
    sem_depth = 0;
    settings_loaded++;
  endtask

  initial begin
    int unsigned fill_ids [16];
    fill_ids = '{1, 2, 4, 8, 16, 32, 42, 63, 42, 21, 0, 7, 56, 3, 62, 9};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with no tokens at all, so every get has to wait.
    load_tokens('0);
    gap_pct = 13;
    queue_call(ActGet, 0, 0);
    queue_call(ActGet, 63, 255);
    queue_call(ActTimeout, 5, 0);      // thread 5 is not waiting: silent
    queue_call(ActTimeout, 0, 0);      // removes the bottom entry
    queue_call(ActPut, 0, 1);          // one token wakes thread 63
    queue_call(ActUnused, 63, 255);    // ignored
    foreach (fill_ids[i]) queue_call(ActGet, fill_ids[i], $urandom_range(255));
    queue_call(ActGet, 5, 0);          // stack is full now
    queue_call(ActTimeout, 42, 0);     // newest of the two 42s, from mid-stack
    queue_call(ActPut, 0, 255);        // wakes the remaining fifteen in one burst
    queue_call(ActPut, 0, 0);          // nothing left to wake
    wait_quiet();

    // Random part, first phase: a few tokens, sender idles now and then.
    load_tokens(TokenW'($urandom_range(1, 5)));
    for (int i = 0; i < 60; i++) queue_random_call(20);
    wait_quiet();

    // Second phase: counter starts at the top, so puts saturate; sender idles a lot.
    load_tokens(TokenW'(TokenCap));
    gap_pct = 55;
    for (int i = 0; i < 30; i++) queue_random_call(25);
    wait_quiet();

    // Third phase: back-to-back calls on a nearly empty counter so the stack fills,
    // overflows and drains in bursts. Halfway through the sender stops and lets
    // every owed event arrive before it carries on.
    load_tokens(TokenW'(1));
    gap_pct = 0;
    for (int i = 0; i < 27; i++) queue_random_call(12);
    wait_quiet();
    for (int i = 0; i < 27; i++) queue_random_call(12);
    wait_quiet();

    $display("Covered %0d calls over %0d token settings with idle and back-to-back phases.",
             calls_taken, settings_loaded);
    $display("Events: %0d granted, %0d queued, %0d resumed, %0d removed, %0d stack full.",
             events_seen[EvGranted], events_seen[EvQueued], events_seen[EvResumed],
             events_seen[EvRemoved], events_seen[EvFull]);
    if (error_count == 0) begin
      $display("PASS counting_semaphore_wait_stack");
    end else begin
      $display("FAIL counting_semaphore_wait_stack");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("FAIL counting_semaphore_wait_stack");
    $finish;
  end

endmodule
